FILE: hdl/mrpq_pkg.sv
package mrpq_pkg;

  localparam int QUEUE_DEPTH = 32;
  localparam int SCAN_COUNT  = 16;

  localparam int IDX_W    = $clog2(QUEUE_DEPTH);
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int QCOUNT_W = 6;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;
  localparam logic [7:0]  BROADCAST_RESET = 8'd127;

  // Register indexes
  localparam logic REG_TIMEOUT   = 1'b0;
  localparam logic REG_BROADCAST = 1'b1;

  // Request kinds
  localparam logic [1:0] KIND_INSERT   = 2'd0;
  localparam logic [1:0] KIND_TICK     = 2'd1;
  localparam logic [1:0] KIND_COMPLETE = 2'd2;
  localparam logic [1:0] KIND_RESCAN   = 2'd3;

  // Result status codes
  localparam logic [3:0] ST_ACCEPTED   = 4'd0;
  localparam logic [3:0] ST_REJECTED   = 4'd1;
  localparam logic [3:0] ST_DISPATCHED = 4'd2;
  localparam logic [3:0] ST_TIMEOUT    = 4'd3;
  localparam logic [3:0] ST_IDLE_EMPTY = 4'd4;
  localparam logic [3:0] ST_WAITING    = 4'd5;
  localparam logic [3:0] ST_FORWARDED  = 4'd6;
  localparam logic [3:0] ST_ABSORBED   = 4'd7;
  localparam logic [3:0] ST_ERROR      = 4'd8;
  localparam logic [3:0] ST_RESCAN     = 4'd9;

  typedef struct packed {
    logic latch;
    logic exec;
    logic walk_start;
    logic walk_step;
    logic commit;
    logic load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       blocked;
    logic       walk_end;
    logic       out_free;
  } dp_stat_t;

endpackage

FILE: hdl/mrpq_ctrl.sv
module mrpq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mrpq_pkg::dp_stat_t stat,
  output mrpq_pkg::ctl_cmd_t cmd
);
  import mrpq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_WALK = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.kind == KIND_INSERT && !stat.blocked) begin
          cmd.walk_start = 1'b1;
          state_next     = S_WALK;
        end else begin
          cmd.exec   = 1'b1;
          state_next = S_DONE;
        end
      end
      S_WALK: begin
        if (stat.walk_end) begin
          cmd.commit = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/mrpq_datapath.sv
module mrpq_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [15:0]                         cfg_data,
  input  logic [1:0]                          in_kind,
  input  logic [7:0]                          in_slave,
  input  logic [7:0]                          in_prio,
  input  logic [15:0]                         in_tag,
  input  logic                                in_err,
  input  mrpq_pkg::ctl_cmd_t                  cmd,
  output mrpq_pkg::dp_stat_t                  stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [3:0]                          out_status,
  output logic [mrpq_pkg::OUT_DATA_W-1:0]     out_data
);
  import mrpq_pkg::*;

  // configuration
  logic [15:0] timeout_limit;
  logic [7:0]  broadcast_address;

  // latched request
  logic [1:0]  it_kind;
  logic [7:0]  it_slave;
  logic [7:0]  it_prio;
  logic [15:0] it_tag;
  logic        it_err;

  // queue cells
  logic [7:0]  e_slave [QUEUE_DEPTH];
  logic [7:0]  e_prio  [QUEUE_DEPTH];
  logic [15:0] e_tag   [QUEUE_DEPTH];

  logic [CNT_W-1:0] count;
  logic             bus_busy;
  logic [15:0]      wait_ticks;
  logic             rescanning;
  logic [7:0]       cur_slave;
  logic [7:0]       cur_prio;
  logic [15:0]      cur_tag;

  // insert walk
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] place;
  logic             dup;
  logic             found;
  logic [7:0]       rd_slave;
  logic [7:0]       rd_prio;

  // staged result
  logic [3:0]  res_status;
  logic [7:0]  res_slave;
  logic [7:0]  res_prio;
  logic [15:0] res_tag;
  logic [CNT_W-1:0] res_count;
  logic        res_resc;

  assign rd_slave = e_slave[idx[IDX_W-1:0]];
  assign rd_prio  = e_prio[idx[IDX_W-1:0]];

  assign stat.kind     = it_kind;
  assign stat.blocked  = rescanning || (count == CNT_W'(QUEUE_DEPTH));
  assign stat.walk_end = (idx == count);
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit     <= TIMEOUT_RESET;
      broadcast_address <= BROADCAST_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIMEOUT:   timeout_limit     <= cfg_data;
        REG_BROADCAST: broadcast_address <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      it_kind  <= in_kind;
      it_slave <= in_slave;
      it_prio  <= in_prio;
      it_tag   <= in_tag;
      it_err   <= in_err;
    end
  end

  // queue cells: each takes its neighbour on a shift, or a new value
  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (cmd.exec && it_kind == KIND_RESCAN) begin
        if (i < SCAN_COUNT) begin
          e_slave[i] <= 8'(i + 1);
        end else begin
          e_slave[i] <= broadcast_address;
        end
        e_prio[i] <= 8'd0;
        e_tag[i]  <= 16'd0;
      end else if (cmd.exec && it_kind == KIND_TICK && !bus_busy && count != '0) begin
        if (i < QUEUE_DEPTH - 1) begin
          e_slave[i] <= e_slave[i+1];
          e_prio[i]  <= e_prio[i+1];
          e_tag[i]   <= e_tag[i+1];
        end
      end else if (cmd.commit && !dup) begin
        if (CNT_W'(i) == place) begin
          e_slave[i] <= it_slave;
          e_prio[i]  <= it_prio;
          e_tag[i]   <= it_tag;
        end else if (i > 0 && CNT_W'(i) > place) begin
          e_slave[i] <= e_slave[i-1];
          e_prio[i]  <= e_prio[i-1];
          e_tag[i]   <= e_tag[i-1];
        end
      end
    end
  end

  // walk over the queued entries for duplicates and the insert place
  always_ff @(posedge clk) begin
    if (cmd.walk_start) begin
      idx   <= '0;
      place <= count;
      dup   <= 1'b0;
      found <= 1'b0;
    end else if (cmd.walk_step) begin
      idx <= idx + 1'b1;
      if (rd_slave == it_slave) begin
        dup <= 1'b1;
      end
      if (!found && rd_prio > it_prio) begin
        found <= 1'b1;
        place <= idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      bus_busy   <= 1'b0;
      wait_ticks <= '0;
      rescanning <= 1'b0;
      cur_slave  <= '0;
      cur_prio   <= '0;
      cur_tag    <= '0;
    end else if (cmd.commit) begin
      res_slave <= '0;
      res_prio  <= '0;
      res_tag   <= '0;
      res_resc  <= rescanning;
      if (dup) begin
        res_status <= ST_REJECTED;
        res_count  <= count;
      end else begin
        res_status <= ST_ACCEPTED;
        count      <= count + 1'b1;
        res_count  <= count + 1'b1;
      end
    end else if (cmd.exec) begin
      res_slave <= cur_slave;
      res_prio  <= cur_prio;
      res_tag   <= cur_tag;
      res_count <= count;
      res_resc  <= rescanning;
      case (it_kind)
        KIND_INSERT: begin
          // blocked insert: rescan active or queue full
          res_status <= ST_REJECTED;
          res_slave  <= '0;
          res_prio   <= '0;
          res_tag    <= '0;
        end
        KIND_TICK: begin
          if (bus_busy) begin
            if (wait_ticks > timeout_limit) begin
              bus_busy   <= 1'b0;
              rescanning <= 1'b0;
              wait_ticks <= '0;
              res_resc   <= 1'b0;
              res_status <= ST_TIMEOUT;
            end else begin
              if (wait_ticks != 16'hFFFF) begin
                wait_ticks <= wait_ticks + 1'b1;
              end
              res_status <= ST_WAITING;
            end
          end else if (count == '0) begin
            rescanning <= 1'b0;
            res_resc   <= 1'b0;
            res_status <= ST_IDLE_EMPTY;
            res_slave  <= '0;
            res_prio   <= '0;
            res_tag    <= '0;
          end else begin
            cur_slave  <= e_slave[0];
            cur_prio   <= e_prio[0];
            cur_tag    <= e_tag[0];
            res_slave  <= e_slave[0];
            res_prio   <= e_prio[0];
            res_tag    <= e_tag[0];
            count      <= count - 1'b1;
            res_count  <= count - 1'b1;
            bus_busy   <= 1'b1;
            wait_ticks <= '0;
            res_status <= ST_DISPATCHED;
          end
        end
        KIND_COMPLETE: begin
          bus_busy <= 1'b0;
          if (it_err) begin
            res_status <= ST_ERROR;
          end else if (rescanning) begin
            res_status <= ST_ABSORBED;
          end else begin
            res_status <= ST_FORWARDED;
          end
        end
        KIND_RESCAN: begin
          count      <= CNT_W'(SCAN_COUNT + 1);
          res_count  <= CNT_W'(SCAN_COUNT + 1);
          rescanning <= 1'b1;
          res_resc   <= 1'b1;
          res_status <= ST_RESCAN;
          res_slave  <= '0;
          res_prio   <= '0;
          res_tag    <= '0;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= res_status;
      out_data   <= {1'b0, res_resc, QCOUNT_W'(res_count), res_tag, res_prio, res_slave};
    end
  end

endmodule

FILE: hdl/modbus_request_priority_queue.sv
// Priority request queue for a serial bus master.
// Input stream s_*: one request per item. s_tuser carries the kind (insert,
// poll tick, completion, start rescan); s_tdata carries the request fields.
// Output stream m_*: exactly one result per request, in order: status in
// m_tuser, the affected request, queue count and rescan flag in m_tdata.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 timeout
// limit, 1 broadcast address). The user must write only while the block is
// idle; the block itself does not enforce this.
// A tick, completion, rescan or blocked insert is latched, executed and its
// result loaded into the output register; an insert instead walks the queued
// entries one per cycle, then is committed before its result is loaded.
// The next request is taken in the cycle after the result is loaded into the
// output register, so no new request is taken while one is being worked on.
// When the receiver stalls, the result is held in the output register and
// the next request is still taken and worked on; its result waits until the
// register is free. Reset empties the queue, frees the bus, ends a rescan
// and restores the configuration defaults (timeout 1000, broadcast 127).
module modbus_request_priority_queue (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // slave_address[7:0], priority_req[15:8], tag[31:16], is_error[32], zeros
  input  logic [mrpq_pkg::IN_DATA_W-1:0]    s_tdata,
  // req_type[1:0]
  input  logic [1:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // out_slave_address[7:0], out_priority[15:8], out_tag[31:16],
  // queue_count[37:32], rescan_active[38], zero[39]
  output logic [mrpq_pkg::OUT_DATA_W-1:0]   m_tdata,
  // status[3:0]
  output logic [3:0]                        m_tuser,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [15:0]                       cfg_data
);
  import mrpq_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  mrpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mrpq_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_kind    (s_tuser),
    .in_slave   (s_tdata[7:0]),
    .in_prio    (s_tdata[15:8]),
    .in_tag     (s_tdata[31:16]),
    .in_err     (s_tdata[32]),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (m_tuser),
    .out_data   (m_tdata)
  );

endmodule
